/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the cycle after ante, skipped while reset is high
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// check cons in the cycle after ante, also across reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/dru_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal round/truncate package
// Payload types, command codes and divide-by-ten constants.
// ----------------------------------------------------------------------------
package dru_pkg;

   localparam int LIMB_W      = 32;
   localparam int NUM_LIMBS   = 3;
   localparam int MAG_W       = LIMB_W * NUM_LIMBS;
   localparam int DIGIT_W     = 4;
   localparam int DIVIDEND_W  = LIMB_W + DIGIT_W;
   localparam int SCALE_W     = 5;
   localparam int DIV10_SHIFT = 39;

   // ceil(2^39 / 10), exact quotient for any dividend below 10 * 2^32
   localparam logic [DIVIDEND_W-1:0] DIV10_RECIP = 36'hCCCCCCCCD;

   localparam logic [DIGIT_W-1:0] ROUND_THRESHOLD = 4'd5;

   typedef enum logic [1:0] {
      CMD_TRUNCATE = 2'd0,
      CMD_FLOOR    = 2'd1,
      CMD_ROUND    = 2'd2,
      CMD_NEGATE   = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [63:0]        magnitude_low;
      logic [31:0]        magnitude_high;
      logic [SCALE_W-1:0] decimal_scale;
      logic               negative;
   } req_type;

   typedef struct packed {
      logic [63:0]        out_magnitude_low;
      logic [31:0]        out_magnitude_high;
      logic [SCALE_W-1:0] out_scale;
      logic               out_negative;
   } rsp_type;

endpackage

/* hdl/decimal_round_truncate_unit.sv */
// ----------------------------------------------------------------------------
// Decimal round/truncate unit
// Truncate, floor, round half away or negate a 96-bit scaled decimal.
// ----------------------------------------------------------------------------
// Usage: an item transfers on req_data when req_valid is high and req_stall
// low. The block then works on that item alone and holds req_stall high.
// Truncate, floor and round strip one decimal digit per pass through one
// shared limb divider; a pass walks the three 32-bit limbs from the top, one
// limb per cycle. After the last pass an adjust state applies the increment,
// and a done state loads the result register once it is free, at which
// point rsp_valid rises. Negate skips the divider and the adjust state and
// goes straight to the done state. The next item is taken in the cycle after
// the result register loads; the block takes no new item while it is still
// working on the last one.
// The result register holds its payload while rsp_stall is high; a new
// input may transfer meanwhile, and its result waits until the register
// frees. A synchronous reset empties the result register and returns the
// block to idle with req_stall low.
// ----------------------------------------------------------------------------
module decimal_round_truncate_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dru_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dru_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ADJUST,
      ST_DONE
   } state_type;

   localparam int LW = dru_pkg::LIMB_W;
   localparam int NL = dru_pkg::NUM_LIMBS;
   localparam int DW = dru_pkg::DIGIT_W;
   localparam int SW = dru_pkg::SCALE_W;
   localparam logic [1:0] TOP_LIMB = 2'(NL - 1);

   state_type               state_ff, state_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [NL-1:0][LW-1:0]   limb_ff, limb_in;
   logic [1:0]              idx_ff, idx_in;
   logic [SW-1:0]           count_ff, count_in;
   logic [SW-1:0]           scale_ff, scale_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           digit_ff, digit_in;
   logic                    sticky_ff, sticky_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dru_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic [LW-1:0]           div_quotient;
   logic [DW-1:0]           div_remainder;
   logic                    take_req;
   logic                    out_free;
   logic                    do_inc;

   dru_div10 u_div10 (
      .dividend  ({rem_ff, limb_ff[idx_ff]}),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign take_req = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign do_inc   = ((cmd_ff == dru_pkg::CMD_FLOOR) && neg_ff && sticky_ff)
                  || ((cmd_ff == dru_pkg::CMD_ROUND) && (scale_ff != '0)
                      && (digit_ff >= dru_pkg::ROUND_THRESHOLD));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      limb_in      = limb_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      scale_in     = scale_ff;
      rem_in       = rem_ff;
      digit_in     = digit_ff;
      sticky_in    = sticky_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               cmd_in    = req_data.command;
               limb_in   = {req_data.magnitude_high, req_data.magnitude_low};
               idx_in    = TOP_LIMB;
               count_in  = req_data.decimal_scale;
               scale_in  = req_data.decimal_scale;
               rem_in    = '0;
               digit_in  = '0;
               sticky_in = 1'b0;
               if (req_data.command == dru_pkg::CMD_NEGATE) begin
                  neg_in   = !req_data.negative;
                  state_in = ST_DONE;
               end else begin
                  neg_in   = req_data.negative;
                  scale_in = req_data.decimal_scale;
                  state_in = (req_data.decimal_scale == '0) ? ST_ADJUST : ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            limb_in[idx_ff] = div_quotient;
            rem_in          = div_remainder;
            if (idx_ff == '0) begin
               digit_in  = div_remainder;
               sticky_in = sticky_ff || (div_remainder != '0);
               rem_in    = '0;
               idx_in    = TOP_LIMB;
               count_in  = count_ff - SW'(1);
               if (count_ff == SW'(1)) begin
                  state_in = ST_ADJUST;
               end
            end else begin
               idx_in = idx_ff - 2'd1;
            end
         end
         ST_ADJUST: begin
            if (do_inc) begin
               limb_in = limb_ff + (NL*LW)'(1);
            end
            scale_in = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.out_magnitude_low  = {limb_ff[1], limb_ff[0]};
               rsp_data_in.out_magnitude_high = limb_ff[2];
               rsp_data_in.out_scale          = scale_ff;
               rsp_data_in.out_negative       = neg_ff;
               state_in                       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      limb_ff     <= limb_in;
      idx_ff      <= idx_in;
      count_ff    <= count_in;
      scale_ff    <= scale_in;
      rem_ff      <= rem_in;
      digit_ff    <= digit_in;
      sticky_ff   <= sticky_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/dru_div10.sv */
// ----------------------------------------------------------------------------
// Limb divide-by-ten unit
// Divides {carried digit, 32-bit limb} by ten with a reciprocal multiply.
// ----------------------------------------------------------------------------
module dru_div10 (
   input  logic [dru_pkg::DIVIDEND_W-1:0] dividend,
   output logic [dru_pkg::LIMB_W-1:0]     quotient,
   output logic [dru_pkg::DIGIT_W-1:0]    remainder
);

   localparam int PROD_W = 2 * dru_pkg::DIVIDEND_W;

   logic [PROD_W-1:0]               product;
   logic [dru_pkg::DIVIDEND_W-1:0]  quotient_x10;

   assign product  = PROD_W'(dividend) * PROD_W'(dru_pkg::DIV10_RECIP);
   assign quotient = product[dru_pkg::DIV10_SHIFT +: dru_pkg::LIMB_W];

   // remainder is below ten, so the low bits of the difference suffice
   assign quotient_x10 = {1'b0, quotient, 3'b000} + {3'b000, quotient, 1'b0};
   assign remainder    = dividend[dru_pkg::DIGIT_W-1:0]
                         - quotient_x10[dru_pkg::DIGIT_W-1:0];

endmodule

/* hdl/dru_checker.sv */
// ----------------------------------------------------------------------------
// Decimal round/truncate checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dru_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dru_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)
   `ASSERT_NEXT_ALWAYS(a_reset_ready, reset, !req_stall)
   `ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall)
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind decimal_round_truncate_unit dru_checker u_dru_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Decimal round/truncate unit testbench
// Sends directed and random scaled decimals through every command. The
// sender works in bursts and the receiver stalls at random. A scoreboard
// predicts each result with plain 96-bit divide-by-ten arithmetic and checks
// every field of every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 400;
   localparam int SETTLE       = 100;

   class rounding_scoreboard;
      dru_pkg::rsp_type expected_results[$];
      int mismatches = 0;
      int checked = 0;
      int per_command[4] = '{0, 0, 0, 0};

      function dru_pkg::rsp_type round_decimal(dru_pkg::req_type item);
         logic [dru_pkg::MAG_W-1:0] mag;
         logic [3:0]                digit;
         bit                        sticky;
         int                        step;
         dru_pkg::rsp_type          r;
         mag    = {item.magnitude_high, item.magnitude_low};
         digit  = '0;
         sticky = 1'b0;
         if (dru_pkg::command_type'(item.command) == dru_pkg::CMD_NEGATE) begin
            r.out_magnitude_low  = item.magnitude_low;
            r.out_magnitude_high = item.magnitude_high;
            r.out_scale          = item.decimal_scale;
            r.out_negative       = ~item.negative;
            return r;
         end
         for (step = 0; step < item.decimal_scale; step++) begin
            digit  = 4'(mag % 10);
            mag    = mag / 10;
            sticky = sticky | (digit != 0);
         end
         case (dru_pkg::command_type'(item.command))
            dru_pkg::CMD_FLOOR: begin
               if (item.negative && sticky) mag = mag + 1;
            end
            dru_pkg::CMD_ROUND: begin
               if (item.decimal_scale != 0 && digit >= dru_pkg::ROUND_THRESHOLD)
                  mag = mag + 1;
            end
            default: ;
         endcase
         r.out_magnitude_low  = mag[63:0];
         r.out_magnitude_high = mag[95:64];
         r.out_scale          = '0;
         r.out_negative       = item.negative;
         return r;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH: %s", what);
      endtask

      function void note_transfer(dru_pkg::req_type item);
         expected_results.push_back(round_decimal(item));
         per_command[item.command]++;
      endfunction

      task check_result(dru_pkg::rsp_type got);
         dru_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", got));
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (got.out_magnitude_low !== want.out_magnitude_low)
            report_mismatch($sformatf("result %0d out_magnitude_low %h, expected %h",
               checked, got.out_magnitude_low, want.out_magnitude_low));
         if (got.out_magnitude_high !== want.out_magnitude_high)
            report_mismatch($sformatf("result %0d out_magnitude_high %h, expected %h",
               checked, got.out_magnitude_high, want.out_magnitude_high));
         if (got.out_scale !== want.out_scale)
            report_mismatch($sformatf("result %0d out_scale %0d, expected %0d",
               checked, got.out_scale, want.out_scale));
         if (got.out_negative !== want.out_negative)
            report_mismatch($sformatf("result %0d out_negative %b, expected %b",
               checked, got.out_negative, want.out_negative));
      endtask

      function int pending();
         return expected_results.size();
      endfunction

      task flag_leftovers();
         if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dru_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dru_pkg::rsp_type rsp_data;

   logic    stall_enabled = 1'b0;
   int      stall_left = 0;
   int      cycle_count = 0;

   rounding_scoreboard board = new();

   decimal_round_truncate_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_transfer(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall  <= stall_enabled && ($urandom_range(0, 2) == 0);
         stall_left <= $urandom_range(0, 6);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
            cycle_count, board.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic dru_pkg::req_type make_item(dru_pkg::command_type cmd,
                                                  logic [dru_pkg::MAG_W-1:0] mag,
                                                  int scale, bit neg);
      dru_pkg::req_type r;
      r.command        = cmd;
      r.magnitude_low  = mag[63:0];
      r.magnitude_high = mag[95:64];
      r.decimal_scale  = scale[dru_pkg::SCALE_W-1:0];
      r.negative       = neg;
      return r;
   endfunction

   function automatic dru_pkg::req_type random_item();
      logic [dru_pkg::MAG_W-1:0] mag;
      logic [dru_pkg::MAG_W-1:0] unit;
      logic [dru_pkg::MAG_W-1:0] span;
      logic [dru_pkg::MAG_W-1:0] frac;
      int                        scale;
      int                        mode;
      int                        s;
      scale = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(0, 28);
      mode  = $urandom_range(0, 9);
      if (mode < 4) begin
         // integer part times a power of ten plus a chosen fraction
         if (scale > 28 || scale == 0) scale = $urandom_range(1, 28);
         unit = 1;
         for (s = 0; s < scale; s++) unit = unit * 10;
         span = {dru_pkg::MAG_W{1'b1}} / unit;
         mag  = {$urandom, $urandom, $urandom} % span;
         if ($urandom_range(0, 1)) mag = mag % 1000;
         case ($urandom_range(0, 4))
            0:       frac = '0;
            1:       frac = unit / 2;
            2:       frac = unit / 2 - 1;
            3:       frac = unit - 1;
            default: frac = {$urandom, $urandom, $urandom} % unit;
         endcase
         mag = mag * unit + frac;
      end else if (mode < 7) begin
         mag = {$urandom, $urandom, $urandom};
      end else if (mode < 9) begin
         mag = dru_pkg::MAG_W'($urandom_range(0, 999));
      end else begin
         case ($urandom_range(0, 2))
            0:       mag = {dru_pkg::MAG_W{1'b1}};
            1:       mag = {{(dru_pkg::MAG_W-1){1'b0}}, 1'b1}
                           << $urandom_range(0, dru_pkg::MAG_W - 1);
            default: mag = ~({{(dru_pkg::MAG_W-1){1'b0}}, 1'b1}
                           << $urandom_range(0, dru_pkg::MAG_W - 1));
         endcase
      end
      return make_item(dru_pkg::command_type'($urandom_range(0, 3)), mag, scale,
                       $urandom_range(0, 1));
   endfunction

   task automatic send_value(input dru_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   initial begin
      logic [dru_pkg::MAG_W-1:0] max_mag;
      int sent;
      int burst;
      int gap;
      int k;
      bit paused;
      max_mag = {dru_pkg::MAG_W{1'b1}};
      sent    = 0;
      paused  = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_value(make_item(dru_pkg::CMD_TRUNCATE, max_mag, 28, 1'b0));
      send_value(make_item(dru_pkg::CMD_FLOOR, max_mag, 28, 1'b1));
      send_value(make_item(dru_pkg::CMD_ROUND, max_mag, 28, 1'b0));
      send_value(make_item(dru_pkg::CMD_NEGATE, max_mag, 28, 1'b0));
      send_value(make_item(dru_pkg::CMD_NEGATE, '0, 0, 1'b1));
      send_value(make_item(dru_pkg::CMD_TRUNCATE, 96'd3, 1, 1'b1));
      send_value(make_item(dru_pkg::CMD_ROUND, 96'd25, 1, 1'b0));
      send_value(make_item(dru_pkg::CMD_ROUND, 96'd25, 1, 1'b1));
      send_value(make_item(dru_pkg::CMD_ROUND, 96'd24, 1, 1'b0));
      send_value(make_item(dru_pkg::CMD_ROUND, 96'd49, 2, 1'b0));
      send_value(make_item(dru_pkg::CMD_ROUND, 96'd5, 1, 1'b0));
      send_value(make_item(dru_pkg::CMD_FLOOR, 96'd21, 1, 1'b1));
      send_value(make_item(dru_pkg::CMD_FLOOR, 96'd20, 1, 1'b1));
      send_value(make_item(dru_pkg::CMD_FLOOR, 96'd27, 1, 1'b0));
      send_value(make_item(dru_pkg::CMD_FLOOR, 96'd123, 0, 1'b1));
      send_value(make_item(dru_pkg::CMD_ROUND, 96'd987, 0, 1'b0));
      send_value(make_item(dru_pkg::CMD_FLOOR, 96'd1, 28, 1'b1));
      send_value(make_item(dru_pkg::CMD_TRUNCATE, '0, 0, 1'b0));
      send_value(make_item(dru_pkg::CMD_TRUNCATE, max_mag, 31, 1'b1));
      send_value(make_item(dru_pkg::CMD_ROUND, max_mag, 29, 1'b1));
      send_value(make_item(dru_pkg::CMD_NEGATE, max_mag, 31, 1'b1));
      send_value(make_item(dru_pkg::CMD_ROUND, max_mag, 1, 1'b0));
      drain_results();

      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         stall_enabled <= ($urandom_range(0, 3) != 0);
         for (k = 0; k < burst; k++) begin
            send_value(random_item());
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      drain_results();
      repeat (SETTLE) @(posedge clock);

      board.flag_leftovers();
      $display("Covered %0d transfers: %0d truncate, %0d floor, %0d round, %0d negate,",
         board.per_command[0] + board.per_command[1] + board.per_command[2]
            + board.per_command[3],
         board.per_command[0], board.per_command[1], board.per_command[2],
         board.per_command[3]);
      $display("scales 0 to 31 with half-way, zero and extreme magnitudes; %0d results, %s",
         board.checked, $sformatf("%0d mismatches.", board.mismatches));
      if (board.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
